FILE: design/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types, widths and the microcode program for the square part
// extractor.
// ----------------------------------------------------------------------------
package spe_pkg;

  // Port widths of the request and result fields.
  localparam int unsigned FIELD_W = 64;
  localparam int unsigned ROOT_W  = 22;

  // Defaults for the top level parameters.
  localparam int unsigned LIMIT_BITS_DEFAULT  = 42;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 64;

  // Microcode address.
  localparam int unsigned UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  // Step addresses of the program.
  localparam upc_t S_IDLE     = 3'd0;
  localparam upc_t S_CHECK    = 3'd1;
  localparam upc_t S_TRIAL    = 3'd2;
  localparam upc_t S_ALIGN    = 3'd3;
  localparam upc_t S_DIVIDE   = 3'd4;
  localparam upc_t S_UPDATE   = 3'd5;
  localparam upc_t S_OUT      = 3'd6;
  localparam upc_t S_OUT_WIDE = 3'd7;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_ALIGN,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_OUT_SPLIT,
    OP_OUT_WIDE
  } op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_START,
    C_WIDE,
    C_ALIGN_MORE,
    C_CNT_NZ,
    C_CONTINUE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  // The program. A taken jump goes to target, otherwise to the next step.
  function automatic ctrl_word_t ucode_rom(upc_t addr);
    ctrl_word_t cw;
    unique case (addr)
      S_IDLE:     cw = '{op: OP_LOAD,      cond: C_NO_START,   target: S_IDLE};
      S_CHECK:    cw = '{op: OP_NOP,       cond: C_WIDE,       target: S_OUT_WIDE};
      S_TRIAL:    cw = '{op: OP_DIV_INIT,  cond: C_NEXT,       target: S_IDLE};
      S_ALIGN:    cw = '{op: OP_ALIGN,     cond: C_ALIGN_MORE, target: S_ALIGN};
      S_DIVIDE:   cw = '{op: OP_DIV_STEP,  cond: C_CNT_NZ,     target: S_DIVIDE};
      S_UPDATE:   cw = '{op: OP_UPDATE,    cond: C_CONTINUE,   target: S_TRIAL};
      S_OUT:      cw = '{op: OP_OUT_SPLIT, cond: C_ALWAYS,     target: S_IDLE};
      S_OUT_WIDE: cw = '{op: OP_OUT_WIDE,  cond: C_ALWAYS,     target: S_IDLE};
      default:    cw = '{op: OP_NOP,       cond: C_ALWAYS,     target: S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

FILE: design/square_part_extractor_unit.sv
// ----------------------------------------------------------------------------
// square_part_extractor_unit
// Splits an unsigned integer n into n = a*a*b with b square-free, by trial
// division over the squares 4, 9, 16, ... under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; value
//   carries n. busy stays high until the result has been given. One result
//   follows each request: root_factor (a) and square_free_part (b) are valid
//   for exactly one cycle while done is high. The receiver cannot stall.
//   An n of 2^LIMIT_BITS or more is returned as a = 1, b = n, straight
//   after the check step. Zero returns a = 2, b = 0.
//   Operation: each trial square runs the steps TRIAL, ALIGN, DIVIDE and
//   UPDATE; the divider is a shift-and-subtract unit that first aligns the
//   square under the remainder, one shift per quotient bit above the first
//   (the bit length of rem/sq less one), and then takes one quotient bit per
//   cycle. Trials run up to the square root of n, so a square-free n near
//   2^42 takes far longer than small values.
//   Reset returns the sequencer to its idle step and drops done; a request
//   in progress is lost.
// ----------------------------------------------------------------------------
module square_part_extractor_unit #(
  parameter int unsigned LIMIT_BITS  = spe_pkg::LIMIT_BITS_DEFAULT,
  parameter int unsigned VALUE_WIDTH = spe_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [spe_pkg::FIELD_W-1:0]  value,
  output logic                         done,
  output logic [spe_pkg::ROOT_W-1:0]   root_factor,
  output logic [spe_pkg::FIELD_W-1:0]  square_free_part
);
  import spe_pkg::*;

  localparam int unsigned L     = LIMIT_BITS;
  localparam int unsigned SQ_W  = L + 1;
  localparam int unsigned ODD_W = (L + 1) / 2 + 3;
  localparam int unsigned CNT_W = $clog2(L);
  localparam logic [FIELD_W:0] MASK_EXT = ({{FIELD_W{1'b0}}, 1'b1} << VALUE_WIDTH)
                                          - {{FIELD_W{1'b0}}, 1'b1};
  localparam logic [FIELD_W-1:0] VALUE_MASK = MASK_EXT[FIELD_W-1:0];

  upc_t               upc;
  upc_t               upc_next;
  ctrl_word_t         cw;
  logic               jump;

  logic [FIELD_W-1:0] vin;
  logic [L-1:0]       rem;
  logic [SQ_W-1:0]    sq;
  logic [ODD_W-1:0]   odd;
  logic [ROOT_W-1:0]  a;
  logic [L-1:0]       d;
  logic [L-1:0]       r;
  logic [L-1:0]       q;
  logic [CNT_W-1:0]   cnt;

  logic [FIELD_W-1:0] value_masked;
  logic               wide;
  logic               align_more;
  logic               div_ge;
  logic [ODD_W-1:0]   root_k;
  logic [SQ_W-1:0]    sq_step;
  logic [SQ_W-1:0]    sq_next;
  logic               stop;

  assign value_masked = value & VALUE_MASK;
  assign wide         = (vin >> L) != '0;
  assign align_more   = {d, 1'b0} <= {1'b0, r};
  assign div_ge       = r >= d;
  assign root_k       = (odd >> 1) + ODD_W'(1);
  assign sq_step      = sq + SQ_W'(odd) + SQ_W'(2);
  assign sq_next      = (r == '0) ? sq : sq_step;
  // The search ends once the remainder is below the square or the square
  // has outgrown the limit.
  assign stop         = (q == '0) || sq_next[L];

  assign cw   = ucode_rom(upc);
  assign busy = (upc != S_IDLE);

  always_comb begin
    unique case (cw.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_START:   jump = !start;
      C_WIDE:       jump = wide;
      C_ALIGN_MORE: jump = align_more;
      C_CNT_NZ:     jump = (cnt != '0);
      C_CONTINUE:   jump = !stop;
      default:      jump = 1'b0;
    endcase
    upc_next = jump ? cw.target : upc + upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc  <= S_IDLE;
      done <= 1'b0;
    end else begin
      upc  <= upc_next;
      done <= 1'b0;
      unique case (cw.op)
        OP_NOP: begin
        end
        OP_LOAD: begin
          vin <= value_masked;
          rem <= L'(value_masked);
          a   <= ROOT_W'(1);
          odd <= ODD_W'(3);
          sq  <= SQ_W'(4);
        end
        OP_DIV_INIT: begin
          d   <= sq[L-1:0];
          r   <= rem;
          q   <= '0;
          cnt <= '0;
        end
        OP_ALIGN: begin
          if (align_more) begin
            d   <= {d[L-2:0], 1'b0};
            cnt <= cnt + CNT_W'(1);
          end
        end
        OP_DIV_STEP: begin
          if (div_ge) begin
            r <= r - d;
            q <= {q[L-2:0], 1'b1};
          end else begin
            q <= {q[L-2:0], 1'b0};
          end
          d <= d >> 1;
          if (cnt != '0) begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        OP_UPDATE: begin
          if (r == '0) begin
            a   <= ROOT_W'(a * root_k);
            rem <= q;
          end else begin
            odd <= odd + ODD_W'(2);
            sq  <= sq_step;
          end
        end
        OP_OUT_SPLIT: begin
          root_factor      <= a;
          square_free_part <= FIELD_W'(rem);
          done             <= 1'b1;
        end
        OP_OUT_WIDE: begin
          root_factor      <= ROOT_W'(1);
          square_free_part <= vin;
          done             <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
